/* rtl/lab_pkg.sv */
// Shared types, constants and helpers of the life-like automaton board.
// Used by the modulo unit, the board and the checker; depends on nothing.

package lab_pkg;

   // Board geometry
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int ROW_BITS   = MAX_WIDTH;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ADDR_BITS  = $clog2(MAX_HEIGHT);

   // Field and register widths
   localparam int DIM_BITS       = 7;
   localparam int COORD_BITS     = 8;
   localparam int MASK_BITS      = 9;
   localparam int FUNC_BITS      = 2;
   localparam int CNT_BITS       = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 9;
   localparam int DIM_MIN        = 3;

   // Coordinate reduction: remainder of |coord| by a size of at least three
   localparam int MOD_STEPS  = 6;
   localparam int MOD_K_BITS = $clog2(MOD_STEPS);
   localparam int SH_BITS    = DIM_BITS + MOD_STEPS;

   // Operation codes
   localparam logic [FUNC_BITS-1:0] FUNC_READ   = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_TOGGLE = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_STEP   = 2'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOARD_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOARD_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRAP_MODE    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIRTH_MASK   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SURVIVE_MASK = 3'd4;

   // Register reset values
   localparam logic [DIM_BITS-1:0]  RST_WIDTH   = DIM_BITS'(MAX_WIDTH);
   localparam logic [DIM_BITS-1:0]  RST_HEIGHT  = DIM_BITS'(MAX_HEIGHT);
   localparam logic [MASK_BITS-1:0] RST_BIRTH   = 9'd8;
   localparam logic [MASK_BITS-1:0] RST_SURVIVE = 9'd12;

   // Request to and answer from the coordinate reduction unit
   typedef struct packed {
      logic                         start;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [DIM_BITS-1:0]          w;
      logic [DIM_BITS-1:0]          h;
   } lab_mod_req_type;

   typedef struct packed {
      logic                 done;
      logic [COL_BITS-1:0]  x;
      logic [ADDR_BITS-1:0] y;
   } lab_mod_rsp_type;

   // Limit a board dimension to DIM_MIN..hi
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                     input logic [DIM_BITS-1:0] hi);
      logic [DIM_BITS-1:0] r;
      if (v < DIM_BITS'(DIM_MIN)) begin
         r = DIM_BITS'(DIM_MIN);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

/* rtl/lab_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.

module lab_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write when enabled; read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/lab_coord_mod.sv */
// Iterative true-modulo unit: reduces a column and a row coordinate by the board size.
// Depends on lab_pkg; one restoring subtract step per cycle on both coordinates.

module lab_coord_mod import lab_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  lab_mod_req_type req,
   output lab_mod_rsp_type rsp
);

   logic [COORD_BITS-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic                  negx_ff, negy_ff;
   logic [DIM_BITS-1:0]   w_ff, h_ff;
   logic [MOD_K_BITS-1:0] k_ff, k_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [SH_BITS-1:0]    dx, dy;
   logic [COORD_BITS-1:0] fx, fy;

   // One restoring step at the current bit position
   always_comb begin
      dx      = SH_BITS'(w_ff) << k_ff;
      dy      = SH_BITS'(h_ff) << k_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      k_in    = k_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (run_ff) begin
         if (SH_BITS'(rx_ff) >= dx) begin
            rx_in = COORD_BITS'(SH_BITS'(rx_ff) - dx);
         end
         if (SH_BITS'(ry_ff) >= dy) begin
            ry_in = COORD_BITS'(SH_BITS'(ry_ff) - dy);
         end
         if (k_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in = k_ff - MOD_K_BITS'(1);
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else if (req.start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         k_ff    <= MOD_K_BITS'(MOD_STEPS - 1);
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         k_ff    <= k_in;
      end
   end

   // Load magnitudes on start, then iterate
   always_ff @(posedge clock) begin
      if (req.start) begin
         negx_ff <= req.x[COORD_BITS-1];
         negy_ff <= req.y[COORD_BITS-1];
         rx_ff   <= req.x[COORD_BITS-1] ? COORD_BITS'(-req.x) : COORD_BITS'(req.x);
         ry_ff   <= req.y[COORD_BITS-1] ? COORD_BITS'(-req.y) : COORD_BITS'(req.y);
         w_ff    <= req.w;
         h_ff    <= req.h;
      end else begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
      end
   end

   // Fold a negative remainder back into 0..size-1
   always_comb begin
      fx = (negx_ff && rx_ff != '0) ? COORD_BITS'(w_ff) - rx_ff : rx_ff;
      fy = (negy_ff && ry_ff != '0) ? COORD_BITS'(h_ff) - ry_ff : ry_ff;
      rsp.done = done_ff;
      rsp.x    = fx[COL_BITS-1:0];
      rsp.y    = fy[ADDR_BITS-1:0];
   end

endmodule

/* rtl/lifelike_automaton_board.sv */
// Life-like cellular automaton board. Clear answers in the cycle after acceptance;
// read and toggle pass a range check and a row read before the result strobe (off the
// board the strobe follows the range check); a wrapped read first runs the six-step
// modulo unit. A generation step walks the rows through the single row memory, a
// read state then a write state per row. One transaction at a time; results cannot
// be stalled. Synchronous reset sets registers to defaults and marks every row dead.

module lifelike_automaton_board import lab_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [FUNC_BITS-1:0]            req_func,
   input  logic signed [COORD_BITS-1:0]    req_x_coord,
   input  logic signed [COORD_BITS-1:0]    req_y_coord,
   output logic                            rsp_valid,
   output logic                            rsp_cell_value,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_data
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MOD    = 4'd1;
   localparam logic [3:0] S_RCHK   = 4'd2;
   localparam logic [3:0] S_RDAT   = 4'd3;
   localparam logic [3:0] S_ST_A   = 4'd4;
   localparam logic [3:0] S_ST_B   = 4'd5;
   localparam logic [3:0] S_ST_C   = 4'd6;
   localparam logic [3:0] S_ROW_RD = 4'd7;
   localparam logic [3:0] S_ROW_WR = 4'd8;

   // Configuration registers
   logic [DIM_BITS-1:0]  width_ff, height_ff;
   logic                 wrap_ff;
   logic [MASK_BITS-1:0] birth_ff, survive_ff;

   // Control and working registers
   logic [3:0]                   state_ff, state_in;
   logic [FUNC_BITS-1:0]         func_ff, func_in;
   logic signed [COORD_BITS-1:0] xc_ff, xc_in, yc_ff, yc_in;
   logic [ADDR_BITS-1:0]         y_ff, y_in;
   logic [ROW_BITS-1:0]          prev_ff, prev_in, cur_ff, cur_in, first_ff, first_in;
   logic [MAX_HEIGHT-1:0]        valid_ff;
   logic                         rd_valid_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_value_ff, rsp_value_in;
   logic                         clear_req;

   // Memory ports
   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   logic [ROW_BITS-1:0]  wr_data, rd_data, row_q;

   // Derived values
   logic [DIM_BITS-1:0]  w_use, h_use;
   logic [COL_BITS-1:0]  w_last;
   logic [ADDR_BITS-1:0] h_last;
   logic                 accept, coord_ok, last_row;
   logic [ROW_BITS-1:0]  below, next_row;
   lab_mod_req_type      mod_req;
   lab_mod_rsp_type      mod_rsp;

   assign w_use     = clamp_dim(width_ff, DIM_BITS'(MAX_WIDTH));
   assign h_use     = clamp_dim(height_ff, DIM_BITS'(MAX_HEIGHT));
   assign w_last    = COL_BITS'(w_use - DIM_BITS'(1));
   assign h_last    = ADDR_BITS'(h_use - DIM_BITS'(1));
   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign row_q     = rd_valid_ff ? rd_data : '0;
   assign last_row  = (y_ff == h_last);
   assign below     = last_row ? (wrap_ff ? first_ff : '0) : row_q;

   // Range check of the held coordinates
   assign coord_ok = !xc_ff[COORD_BITS-1] && !yc_ff[COORD_BITS-1] &&
                     (DIM_BITS'(xc_ff[COORD_BITS-2:0]) < w_use) &&
                     (DIM_BITS'(yc_ff[COORD_BITS-2:0]) < h_use);

   // Start the modulo unit for a wrapped read
   always_comb begin
      mod_req.start = accept && (req_func == FUNC_READ) && wrap_ff;
      mod_req.x     = req_x_coord;
      mod_req.y     = req_y_coord;
      mod_req.w     = w_use;
      mod_req.h     = h_use;
   end

   lab_coord_mod u_coord_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   lab_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (MAX_HEIGHT)
   ) u_rows (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next generation of the current row, one lane per column
   always_comb begin
      logic [CNT_BITS-1:0]  n;
      logic                 pl, pr, cl, cr, bl, br, alive;
      logic [MASK_BITS-1:0] rule;
      next_row = cur_ff;
      for (int i = 0; i < ROW_BITS; i++) begin
         if (i == 0) begin
            pl = wrap_ff && prev_ff[w_last];
            cl = wrap_ff && cur_ff[w_last];
            bl = wrap_ff && below[w_last];
         end else begin
            pl = prev_ff[i-1];
            cl = cur_ff[i-1];
            bl = below[i-1];
         end
         if (COL_BITS'(i) == w_last) begin
            pr = wrap_ff && prev_ff[0];
            cr = wrap_ff && cur_ff[0];
            br = wrap_ff && below[0];
         end else if (i < ROW_BITS - 1) begin
            pr = prev_ff[i+1];
            cr = cur_ff[i+1];
            br = below[i+1];
         end else begin
            pr = 1'b0;
            cr = 1'b0;
            br = 1'b0;
         end
         n = CNT_BITS'(pl) + CNT_BITS'(prev_ff[i]) + CNT_BITS'(pr) +
             CNT_BITS'(cl) + CNT_BITS'(cr) +
             CNT_BITS'(bl) + CNT_BITS'(below[i]) + CNT_BITS'(br);
         rule  = cur_ff[i] ? survive_ff : birth_ff;
         alive = rule[n];
         if (DIM_BITS'(i) < w_use) begin
            next_row[i] = alive;
         end
      end
   end

   // Sequencer: decode, read-modify-write, generation walk
   always_comb begin
      logic [COL_BITS-1:0] col;
      logic                old_bit;
      col          = xc_ff[COL_BITS-1:0];
      old_bit      = row_q[col];
      state_in     = state_ff;
      func_in      = func_ff;
      xc_in        = xc_ff;
      yc_in        = yc_ff;
      y_in         = y_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      first_in     = first_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = 1'b0;
      clear_req    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = yc_ff[ADDR_BITS-1:0];
      wr_data      = row_q ^ (ROW_BITS'(1) << col);
      rd_addr      = yc_ff[ADDR_BITS-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in = req_func;
               xc_in   = req_x_coord;
               yc_in   = req_y_coord;
               unique case (req_func)
                  FUNC_READ:   state_in = wrap_ff ? S_MOD : S_RCHK;
                  FUNC_TOGGLE: state_in = S_RCHK;
                  FUNC_STEP:   state_in = S_ST_A;
                  default: begin
                     clear_req    = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_MOD: begin
            if (mod_rsp.done) begin
               xc_in    = COORD_BITS'(mod_rsp.x);
               yc_in    = COORD_BITS'(mod_rsp.y);
               state_in = S_RCHK;
            end
         end
         S_RCHK: begin
            if (coord_ok) begin
               state_in = S_RDAT;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RDAT: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (func_ff == FUNC_TOGGLE) begin
               wr_en        = 1'b1;
               rsp_value_in = !old_bit;
            end else begin
               rsp_value_in = old_bit;
            end
         end
         S_ST_A: begin
            rd_addr  = '0;
            state_in = S_ST_B;
         end
         S_ST_B: begin
            first_in = row_q;
            cur_in   = row_q;
            rd_addr  = h_last;
            state_in = S_ST_C;
         end
         S_ST_C: begin
            prev_in  = wrap_ff ? row_q : '0;
            y_in     = '0;
            state_in = S_ROW_RD;
         end
         S_ROW_RD: begin
            rd_addr  = y_ff + ADDR_BITS'(1);
            state_in = S_ROW_WR;
         end
         S_ROW_WR: begin
            wr_en   = 1'b1;
            wr_addr = y_ff;
            wr_data = next_row;
            prev_in = cur_ff;
            cur_in  = below;
            if (last_row) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               y_in     = y_ff + ADDR_BITS'(1);
               state_in = S_ROW_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state and row valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= valid_ff[rd_addr];
         if (clear_req) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      xc_ff        <= xc_in;
      yc_ff        <= yc_in;
      y_ff         <= y_in;
      prev_ff      <= prev_in;
      cur_ff       <= cur_in;
      first_ff     <= first_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Configuration writes; indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= RST_WIDTH;
         height_ff  <= RST_HEIGHT;
         wrap_ff    <= 1'b0;
         birth_ff   <= RST_BIRTH;
         survive_ff <= RST_SURVIVE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOARD_WIDTH:  width_ff   <= csr_data[DIM_BITS-1:0];
            CSR_BOARD_HEIGHT: height_ff  <= csr_data[DIM_BITS-1:0];
            CSR_WRAP_MODE:    wrap_ff    <= csr_data[0];
            CSR_BIRTH_MASK:   birth_ff   <= csr_data[MASK_BITS-1:0];
            CSR_SURVIVE_MASK: survive_ff <= csr_data[MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

endmodule

/* rtl/lab_checker.sv */
// Port-level checker for the automaton board, bound to the top level.
// Depends on lab_pkg for the operation codes.

module lab_checker import lab_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [FUNC_BITS-1:0]         req_func,
   input logic                         rsp_valid,
   input logic                         rsp_cell_value
);

   // An accepted transaction either keeps the block busy or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction made no progress");

   // A clear answers in the next cycle with a dead cell
   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_CLEAR) |=> (rsp_valid && !rsp_cell_value))
      else $error("clear did not answer with zero");

   // A result arrives only once the block is idle again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // The end of a busy period delivers its result
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy dropped without a result");

   // No result without a transaction in flight
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(reset)) |-> ($past(busy) || $past(start)))
      else $error("result strobe without a transaction");

endmodule

bind lifelike_automaton_board lab_checker u_lab_checker (.*);
